// File: src/pewq_pkg.sv
`default_nettype none

package pewq_pkg;

  localparam int TASK_W     = 6;
  localparam int LINK_W     = TASK_W + 1;
  localparam int PERIOD_W   = 16;
  localparam int MILLIS_W   = 32;
  localparam int NUM_REGS   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int RESULT_CAP = 64;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);

  localparam logic OP_WAIT = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET [NUM_REGS] = '{
    16'd100, 16'd200, 16'd500, 16'd50
  };

  typedef struct packed {
    logic                operation;
    logic [1:0]          source;
    logic [TASK_W-1:0]   task_id;
    logic [MILLIS_W-1:0] millis;
  } request_t;

  typedef struct packed {
    logic              has_task;
    logic [TASK_W-1:0] woken_task;
    logic              reschedule;
    logic              last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_CHECK,
    ST_DIV,
    ST_DRAIN,
    ST_POP,
    ST_FINISH
  } state_t;

  function automatic logic [PERIOD_W-1:0] period_init(input int idx);
    logic [PERIOD_W-1:0] val;
    val = '0;
    if (idx < NUM_REGS) begin
      val = PERIOD_RESET[CFG_IDX_W'(idx)];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// File: src/periodic_event_wait_queues.sv
// Channel   Ports                          Transfer
// -------   -----------------------------  -------------------------------------
// request   start, busy, request           edge with start high and busy low
// result    result_valid, result           every cycle result_valid is high
// config    cfg_write, cfg_index, cfg_data edge with cfg_write high
//
// A wait writes the link at the tail, or sets the head of an empty queue, then
// clears the link of the new entry. A tick checks each source in turn: it skips
// one whose period or millis is zero, else runs the shared 1 bit per cycle remainder
// unit; each woken task takes a link memory read and write-back, each drained queue a check.
// Synchronous reset empties all queues and loads the default periods.
// Results are not held: the receiver takes each one in its strobe cycle.
`default_nettype none

module periodic_event_wait_queues #(
  parameter int NUM_SOURCES = 4,
  parameter int MAX_TASKS   = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  pewq_pkg::request_t             request,
  output logic                           result_valid,
  output pewq_pkg::result_t              result,
  input  logic                           cfg_write,
  input  logic [pewq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pewq_pkg::PERIOD_W-1:0]  cfg_data
);

  import pewq_pkg::*;

  localparam int SRC_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int TASK_AW = $clog2(MAX_TASKS);

  state_t state, state_next;

  logic [PERIOD_W-1:0] period    [NUM_SOURCES];
  logic [LINK_W-1:0]   head_link [NUM_SOURCES];
  logic [TASK_W-1:0]   tail      [NUM_SOURCES];

  logic [SRC_W-1:0]    src_q;
  logic [TASK_W-1:0]   task_q;
  logic [MILLIS_W-1:0] millis_q;
  logic [SRC_W-1:0]    s_q;
  logic [CNT_W-1:0]    n_q;
  logic                pend_valid;
  logic [TASK_W-1:0]   pend_task;

  logic                accept;
  logic                req_ok;
  logic [SRC_W-1:0]    src_i;
  logic [SRC_W-1:0]    q_idx;
  logic [LINK_W-1:0]   head_cur;
  logic [TASK_W-1:0]   tail_cur;
  logic [PERIOD_W-1:0] period_cur;
  logic                last_src;
  logic                skip_src;
  logic                cap_hit;

  logic                ram_we;
  logic [TASK_AW-1:0]  ram_waddr;
  logic [LINK_W-1:0]   ram_wdata;
  logic [TASK_AW-1:0]  ram_raddr;
  logic [LINK_W-1:0]   ram_rdata;
  logic                rem_start;
  logic                rem_done;
  logic                rem_zero;

  logic                head_set;
  logic                adv;
  logic                emit;
  result_t             emit_res;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign req_ok     = (32'(request.source) < NUM_SOURCES) && (32'(request.task_id) < MAX_TASKS);
  assign src_i      = SRC_W'(request.source);
  assign q_idx      = (state == ST_IDLE) ? src_i : s_q;
  assign head_cur   = head_link[q_idx];
  assign tail_cur   = tail[q_idx];
  assign period_cur = period[s_q];
  assign last_src   = (s_q == SRC_W'(NUM_SOURCES - 1));
  assign skip_src   = (millis_q == '0) || (period_cur == '0);
  assign cap_hit    = (n_q == CNT_W'(RESULT_CAP));
  assign ram_raddr  = TASK_AW'(head_cur[TASK_W-1:0]);

  pewq_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_TASKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pewq_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (millis_q),
    .divisor  (period_cur),
    .done     (rem_done),
    .is_zero  (rem_zero)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (request.operation == OP_TICK) begin
            state_next = ST_CHECK;
          end else if (req_ok) begin
            state_next = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        state_next = ST_IDLE;
      end
      ST_CHECK: begin
        if (!skip_src) begin
          state_next = ST_DIV;
        end else begin
          state_next = last_src ? ST_FINISH : ST_CHECK;
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          if (rem_zero) begin
            state_next = ST_DRAIN;
          end else begin
            state_next = last_src ? ST_FINISH : ST_CHECK;
          end
        end
      end
      ST_DRAIN: begin
        if (cap_hit) begin
          state_next = ST_FINISH;
        end else if (head_cur[TASK_W]) begin
          state_next = ST_POP;
        end else begin
          state_next = last_src ? ST_FINISH : ST_CHECK;
        end
      end
      ST_POP: begin
        state_next = ST_DRAIN;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = TASK_AW'(task_q);
    ram_wdata = '0;
    rem_start = 1'b0;
    head_set  = 1'b0;
    adv       = 1'b0;
    emit      = 1'b0;
    emit_res  = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && (request.operation == OP_WAIT) && req_ok) begin
          if (head_cur[TASK_W]) begin
            ram_we    = 1'b1;
            ram_waddr = TASK_AW'(tail_cur);
            ram_wdata = {1'b1, request.task_id};
          end else begin
            head_set = 1'b1;
          end
        end
      end
      ST_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = TASK_AW'(task_q);
        ram_wdata = '0;
      end
      ST_CHECK: begin
        rem_start = !skip_src;
        adv       = skip_src;
      end
      ST_DIV: begin
        adv = rem_done && !rem_zero;
      end
      ST_DRAIN: begin
        adv = !cap_hit && !head_cur[TASK_W];
      end
      ST_POP: begin
        ram_we    = 1'b1;
        ram_waddr = TASK_AW'(head_cur[TASK_W-1:0]);
        ram_wdata = '0;
        emit      = pend_valid;
        emit_res  = '{has_task: 1'b1, woken_task: pend_task, reschedule: 1'b0, last: 1'b0};
      end
      ST_FINISH: begin
        emit = 1'b1;
        if (pend_valid) begin
          emit_res = '{has_task: 1'b1, woken_task: pend_task, reschedule: 1'b1, last: 1'b1};
        end else begin
          emit_res = '{has_task: 1'b0, woken_task: '0, reschedule: 1'b0, last: 1'b1};
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      s_q          <= '0;
      n_q          <= '0;
      pend_valid   <= 1'b0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        period[i]    <= period_init(i);
        head_link[i] <= '0;
        tail[i]      <= '0;
      end
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (cfg_write && (32'(cfg_index) < NUM_REGS) && (32'(cfg_index) < NUM_SOURCES)) begin
        period[SRC_W'(cfg_index)] <= cfg_data;
      end
      if (accept) begin
        s_q        <= '0;
        n_q        <= '0;
        pend_valid <= 1'b0;
      end
      if (head_set) begin
        head_link[q_idx] <= {1'b1, request.task_id};
      end
      if (state == ST_APPEND) begin
        tail[src_q] <= task_q;
      end
      if (adv && !last_src) begin
        s_q <= s_q + 1'b1;
      end
      if (state == ST_POP) begin
        head_link[s_q] <= ram_rdata;
        n_q            <= n_q + 1'b1;
        pend_valid     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_q    <= src_i;
      task_q   <= request.task_id;
      millis_q <= request.millis;
    end
    if (state == ST_POP) begin
      pend_task <= head_cur[TASK_W-1:0];
    end
    result <= emit_res;
  end

endmodule

`default_nettype wire

// File: src/pewq_ram.sv
`default_nettype none

module pewq_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/pewq_rem.sv
`default_nettype none

module pewq_rem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pewq_pkg::MILLIS_W-1:0] dividend,
  input  logic [pewq_pkg::PERIOD_W-1:0] divisor,
  output logic                          done,
  output logic                          is_zero
);

  import pewq_pkg::*;

  localparam int STEP_W = $clog2(MILLIS_W);

  logic                running;
  logic [STEP_W-1:0]   step;
  logic [MILLIS_W-1:0] quo;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W-1:0] dvs;
  logic [PERIOD_W:0]   shifted;
  logic [PERIOD_W:0]   diff;
  logic [PERIOD_W-1:0] rem_next;

  // restoring division, one quotient bit per cycle
  assign shifted  = {rem, quo[MILLIS_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign rem_next = (shifted >= {1'b0, dvs}) ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
  assign is_zero  = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == STEP_W'(MILLIS_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= {quo[MILLIS_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

// File: dv/periodic_event_wait_queues_tb.sv
`timescale 1ns / 1ps

module periodic_event_wait_queues_tb;
  import pewq_pkg::*;

  localparam int SOURCES = 4;
  localparam int TASKS   = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SRC0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SRC1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SRC2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SRC3 = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  request_t             request = '0;
  logic                 result_valid;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PERIOD_W-1:0]  cfg_data = '0;

  periodic_event_wait_queues dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .result_valid(result_valid),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the wait queues and period registers
  logic [PERIOD_W-1:0] shadow_period [SOURCES];
  logic [LINK_W-1:0]   shadow_head [SOURCES];
  logic [TASK_W-1:0]   shadow_tail [SOURCES];
  logic [LINK_W-1:0]   shadow_link [TASKS];
  logic                queued [TASKS];

  result_t expected_wakes [$];

  int  mismatches = 0;
  int  waits_sent = 0;
  int  ticks_sent = 0;
  int  woken_total = 0;
  int  empty_ticks = 0;
  int  capped_ticks = 0;
  int  settings_used = 1;
  bit  no_idle = 1'b0;

  function automatic void predict_wait(input logic [1:0] src, input logic [TASK_W-1:0] id);
    waits_sent++;
    if (shadow_head[src][TASK_W]) begin
      shadow_link[shadow_tail[src]] = {1'b1, id};
    end else begin
      shadow_head[src] = {1'b1, id};
    end
    shadow_link[id] = '0;
    shadow_tail[src] = id;
    queued[id] = 1'b1;
  endfunction

  function automatic void predict_tick(input logic [MILLIS_W-1:0] ms);
    logic [TASK_W-1:0] woke [RESULT_CAP];
    logic [TASK_W-1:0] t;
    result_t           r;
    int                n;
    n = 0;
    ticks_sent++;
    for (int s = 0; s < SOURCES; s++) begin
      if (ms != 0 && shadow_period[s] != 0 && ms % shadow_period[s] == 0) begin
        while (shadow_head[s][TASK_W] && n < RESULT_CAP) begin
          t = shadow_head[s][TASK_W-1:0];
          woke[n] = t;
          n++;
          shadow_head[s] = shadow_link[t];
          shadow_link[t] = '0;
          queued[t] = 1'b0;
        end
      end
    end
    if (n == 0) begin
      empty_ticks++;
      r.has_task = 1'b0;
      r.woken_task = '0;
      r.reschedule = 1'b0;
      r.last = 1'b1;
      expected_wakes.push_back(r);
    end
    for (int k = 0; k < n; k++) begin
      r.has_task = 1'b1;
      r.woken_task = woke[k];
      r.reschedule = (k == n - 1);
      r.last = (k == n - 1);
      expected_wakes.push_back(r);
    end
    woken_total += n;
    if (n == RESULT_CAP) capped_ticks++;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void check_field(input string name, input logic [TASK_W-1:0] want,
                                      input logic [TASK_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (expected_wakes.size() == 0) begin
        $display("%0t ns: unexpected result, actual has=%0d task=%0d resched=%0d last=%0d",
                 $time, result.has_task, result.woken_task, result.reschedule, result.last);
        mismatches++;
      end else begin
        want = expected_wakes.pop_front();
        check_field("has_task", TASK_W'(want.has_task), TASK_W'(result.has_task));
        check_field("woken_task", want.woken_task, result.woken_task);
        check_field("reschedule", TASK_W'(want.reschedule), TASK_W'(result.reschedule));
        check_field("last", TASK_W'(want.last), TASK_W'(result.last));
      end
    end
  end

  // start stays high across back-to-back transfers
  task automatic issue_request(input request_t req);
    int gap;
    request <= req;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req.operation == OP_WAIT) predict_wait(req.source, req.task_id);
    else predict_tick(req.millis);
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_wait(input logic [1:0] src, input logic [TASK_W-1:0] id);
    request_t req;
    req.operation = OP_WAIT;
    req.source = src;
    req.task_id = id;
    req.millis = $urandom();
    issue_request(req);
  endtask

  task automatic send_tick(input logic [MILLIS_W-1:0] ms);
    request_t req;
    req.operation = OP_TICK;
    req.source = 2'($urandom_range(3));
    req.task_id = TASK_W'($urandom_range(TASKS - 1));
    req.millis = ms;
    issue_request(req);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_wakes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    shadow_period[idx] = val;
  endtask

  task automatic set_periods(input logic [PERIOD_W-1:0] p0, input logic [PERIOD_W-1:0] p1,
                             input logic [PERIOD_W-1:0] p2, input logic [PERIOD_W-1:0] p3);
    wait_idle();
    write_reg(REG_PERIOD_SRC0, p0);
    write_reg(REG_PERIOD_SRC1, p1);
    write_reg(REG_PERIOD_SRC2, p2);
    write_reg(REG_PERIOD_SRC3, p3);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic test_default_periods();
    send_wait(2'd0, 6'd1);
    send_wait(2'd1, 6'd2);
    send_wait(2'd2, 6'd3);
    send_wait(2'd3, 6'd4);
    send_wait(2'd3, 6'd5);
    send_tick(32'd0);
    send_tick(32'd7);
    send_tick(32'd50);
    send_tick(32'd100);
    send_tick(32'd1000);
  endtask

  task automatic test_period_extremes();
    set_periods(16'd0, 16'hFFFF, 16'd1, 16'hFFFF);
    send_wait(2'd0, 6'd0);
    send_wait(2'd1, 6'd63);
    send_wait(2'd2, 6'd42);
    send_wait(2'd3, 6'd21);
    send_tick(32'hFFFF_FFFF);
    send_wait(2'd2, 6'd10);
    send_tick(32'd0);
    send_tick(32'd65534);
  endtask

  // a task joining a second list cuts the first list at that task
  task automatic test_repeat_wait();
    set_periods(16'd100, 16'd200, 16'd500, 16'd50);
    send_wait(2'd0, 6'd5);
    send_wait(2'd0, 6'd6);
    send_wait(2'd1, 6'd5);
    send_wait(2'd0, 6'd7);
    send_wait(2'd2, 6'd9);
    send_wait(2'd2, 6'd9);
    send_tick(32'd1000);
  endtask

  task automatic test_result_budget();
    set_periods(16'd1, 16'd2, 16'd0, 16'd0);
    for (int i = 0; i < TASKS; i++) send_wait(2'd0, TASK_W'(i));
    send_wait(2'd1, 6'd63);
    send_tick(32'd2);
    send_tick(32'd4);
  endtask

  task automatic test_random_traffic(input int count, input bit steady);
    logic [1:0]          src;
    logic [TASK_W-1:0]   id;
    logic [MILLIS_W-1:0] ms;
    int                  pick;
    int                  tries;
    no_idle = steady;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 50) begin
        src = 2'($urandom_range(3));
        id = TASK_W'($urandom_range(TASKS - 1));
        if ($urandom_range(99) >= 8) begin
          tries = 0;
          while (queued[id] && tries < TASKS) begin
            id = id + 1'b1;
            tries++;
          end
        end
        send_wait(src, id);
      end else begin
        pick = $urandom_range(99);
        src = 2'($urandom_range(3));
        if (pick < 60 && shadow_period[src] != 0) begin
          ms = shadow_period[src] * $urandom_range(1, 2000);
        end else if (pick < 72) begin
          ms = 1;
          for (int i = 0; i < SOURCES; i++) begin
            if (shadow_period[i] != 0) ms = ms * shadow_period[i];
          end
        end else if (pick < 92) begin
          ms = $urandom();
        end else begin
          ms = '0;
        end
        send_tick(ms);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int guard;
    for (int i = 0; i < SOURCES; i++) begin
      shadow_period[i] = PERIOD_RESET[i];
      shadow_head[i] = '0;
      shadow_tail[i] = '0;
    end
    for (int i = 0; i < TASKS; i++) begin
      shadow_link[i] = '0;
      queued[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_periods();
    test_period_extremes();
    test_repeat_wait();
    test_result_budget();

    set_periods(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
    test_random_traffic(20, 1'b0);
    set_periods(16'($urandom_range(1, 600)), 16'd0,
                16'($urandom_range(1, 600)), 16'($urandom_range(1, 600)));
    test_random_traffic(20, 1'b0);
    set_periods(16'd1, 16'd2, 16'd3, 16'd4);
    test_random_traffic(20, 1'b1);
    set_periods(16'($urandom()), 16'hFFFF, 16'($urandom_range(1, 9)), 16'd0);
    test_random_traffic(18, 1'b0);

    start <= 1'b0;
    guard = 0;
    while (expected_wakes.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    if (expected_wakes.size() != 0) begin
      $display("%0t ns: %0d results missing, next expected has_task=%0d woken_task=%0d",
               $time, expected_wakes.size(), expected_wakes[0].has_task,
               expected_wakes[0].woken_task);
      mismatches++;
    end

    $display("Covered %0d waits and %0d ticks over %0d period settings;", waits_sent,
             ticks_sent, settings_used);
    $display("%0d tasks woken, %0d ticks woke nothing, %0d ticks hit the result budget.",
             woken_total, empty_ticks, capped_ticks);
    if (mismatches == 0) begin
      $display("periodic_event_wait_queues test passed");
    end else begin
      $display("periodic_event_wait_queues test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t ns: timeout, %0d results still expected", $time, expected_wakes.size());
    $display("periodic_event_wait_queues test failed");
    $finish;
  end

endmodule
